FILE: hdl/fspa_pkg.sv
package fspa_pkg;

	localparam int MAX_SLOTS = 256;
	localparam int MIN_SLOTS = 2;
	localparam int IDX_W = 8;
	localparam int CODE_W = 9;

	localparam logic [CODE_W-1:0] CODE_END = CODE_W'(MAX_SLOTS);
	localparam logic [CODE_W-1:0] CODE_ALLOCATED = CODE_W'(MAX_SLOTS + 1);

	typedef enum logic [1:0] {
		OP_REINIT = 2'd0,
		OP_ALLOC  = 2'd1,
		OP_FREE   = 2'd2,
		OP_CHECK  = 2'd3
	} op_t;

	typedef enum logic [1:0] {
		ST_OK      = 2'd0,
		ST_FULL    = 2'd1,
		ST_INVALID = 2'd2
	} status_t;

	typedef struct packed {
		op_t              op;
		logic [IDX_W-1:0] slot_index;
	} req_t;

	typedef struct packed {
		status_t           status;
		logic [IDX_W-1:0]  granted_slot;
		logic [CODE_W-1:0] free_count;
	} rsp_t;

	typedef enum logic [1:0] {
		S_IDLE,
		S_EXEC,
		S_FILL
	} state_t;

	typedef struct packed {
		logic accept;
		logic exec;
		logic fill;
		logic fill_done;
	} ctrl_cmd_t;

	typedef struct packed {
		logic req_fill;
		logic fill_last;
	} dp_status_t;

endpackage

FILE: hdl/fixed_slot_pool_allocator.sv
// Fixed-slot pool allocator. Raise start with a request while busy is low;
// allocate, free and check pass through the execute state: busy is high in
// the cycle after start, and the result appears on rsp with done high for
// exactly one cycle after that, when busy is already low again, so a new
// request may be issued in the same cycle as a result is shown. done cannot
// be held off: capture rsp in the cycle done is high. The execute state is
// needed because the read data of the next-slot table is registered.
// A reinitialise with a valid pool size (cfg_wdata of 2..256, applied at the
// next reinitialise) walks the table one slot per cycle in the fill state;
// with a bad pool size it behaves like any other request. Every request
// other than a valid reinitialise reports invalid until the first
// reinitialise completes. Write cfg only while the block is idle.
module fixed_slot_pool_allocator (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           start,
	input  fspa_pkg::req_t req,
	output logic           busy,
	output logic           done,
	output fspa_pkg::rsp_t rsp,
	input  logic           cfg_we,
	input  logic [8:0]     cfg_wdata
);
	import fspa_pkg::*;

	ctrl_cmd_t  cmd;
	dp_status_t status;

	fspa_ctrl u_ctrl (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.status (status),
		.busy   (busy),
		.cmd    (cmd)
	);

	fspa_datapath u_datapath (
		.clk       (clk),
		.arst_n    (arst_n),
		.req       (req),
		.cmd       (cmd),
		.cfg_we    (cfg_we),
		.cfg_wdata (cfg_wdata),
		.status    (status),
		.done      (done),
		.rsp       (rsp)
	);

endmodule

FILE: hdl/fspa_ctrl.sv
module fspa_ctrl (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                start,
	input  fspa_pkg::dp_status_t status,
	output logic                busy,
	output fspa_pkg::ctrl_cmd_t  cmd
);
	import fspa_pkg::*;

	state_t state_q;
	state_t state_nxt;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_nxt;
		end
	end

	always_comb begin
		state_nxt = state_q;
		unique case (state_q)
			S_IDLE: begin
				if (start) begin
					state_nxt = status.req_fill ? S_FILL : S_EXEC;
				end
			end
			S_EXEC: begin
				state_nxt = S_IDLE;
			end
			S_FILL: begin
				if (status.fill_last) begin
					state_nxt = S_IDLE;
				end
			end
			default: begin
				state_nxt = S_IDLE;
			end
		endcase
	end

	always_comb begin
		busy = 1'b1;
		cmd = '0;
		unique case (state_q)
			S_IDLE: begin
				busy = 1'b0;
				cmd.accept = start;
			end
			S_EXEC: begin
				cmd.exec = 1'b1;
			end
			S_FILL: begin
				cmd.fill = 1'b1;
				cmd.fill_done = status.fill_last;
			end
			default: begin
				busy = 1'b1;
			end
		endcase
	end

	// a valid reinit request must start the fill walk
	assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy && status.req_fill) |=> (state_q == S_FILL))
		else $error("fill walk not started");

	// a plain request leaves execute for idle in the next cycle
	assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_EXEC) |=> (state_q == S_IDLE))
		else $error("execute state held");

endmodule

FILE: hdl/fspa_datapath.sv
module fspa_datapath (
	input  logic                 clk,
	input  logic                 arst_n,
	input  fspa_pkg::req_t        req,
	input  fspa_pkg::ctrl_cmd_t   cmd,
	input  logic                 cfg_we,
	input  logic [8:0]           cfg_wdata,
	output fspa_pkg::dp_status_t  status,
	output logic                 done,
	output fspa_pkg::rsp_t        rsp
);
	import fspa_pkg::*;

	logic [CODE_W-1:0] mem [MAX_SLOTS];
	logic [CODE_W-1:0] rdata_q;
	logic [IDX_W-1:0]  raddr;
	logic              we;
	logic [IDX_W-1:0]  waddr;
	logic [CODE_W-1:0] wdata;

	logic [CODE_W-1:0] cfg_q;
	op_t               op_q;
	logic [IDX_W-1:0]  idx_q;
	logic [CODE_W-1:0] head_q;
	logic [CODE_W-1:0] used_q;
	logic [CODE_W-1:0] pool_q;
	logic              init_q;
	logic [IDX_W-1:0]  fill_cnt_q;
	logic [CODE_W-1:0] fill_n_q;
	logic              done_q;
	rsp_t              rsp_q;

	logic              size_ok;
	logic [CODE_W-1:0] fill_next;
	logic              alloc_ok;
	logic              alloc_full;
	logic              slot_alloc;
	logic              free_ok;
	logic [CODE_W-1:0] free_now;
	rsp_t              rsp_nxt;

	assign size_ok = (cfg_q >= CODE_W'(MIN_SLOTS)) && (cfg_q <= CODE_W'(MAX_SLOTS));
	assign fill_next = {1'b0, fill_cnt_q} + CODE_W'(1);
	assign status.req_fill = (req.op == OP_REINIT) && size_ok;
	assign status.fill_last = (fill_next == fill_n_q);

	assign free_now = init_q ? (pool_q - used_q) : '0;
	assign alloc_full = (used_q >= pool_q) || (head_q >= pool_q);
	assign alloc_ok = (op_q == OP_ALLOC) && init_q && !alloc_full;
	assign slot_alloc = init_q && (used_q != '0) && ({1'b0, idx_q} < pool_q)
		&& (rdata_q == CODE_ALLOCATED);
	assign free_ok = (op_q == OP_FREE) && slot_alloc;

	// read the head for allocate, the requested slot otherwise
	assign raddr = (req.op == OP_ALLOC) ? head_q[IDX_W-1:0] : req.slot_index;

	always_comb begin
		we = 1'b0;
		waddr = fill_cnt_q;
		wdata = (fill_next < fill_n_q) ? fill_next : CODE_END;
		if (cmd.fill) begin
			we = 1'b1;
		end else if (cmd.exec && alloc_ok) begin
			we = 1'b1;
			waddr = head_q[IDX_W-1:0];
			wdata = CODE_ALLOCATED;
		end else if (cmd.exec && free_ok) begin
			we = 1'b1;
			waddr = idx_q;
			wdata = head_q;
		end
	end

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata_q <= mem[raddr];
	end

	always_comb begin
		rsp_nxt.status = ST_INVALID;
		rsp_nxt.granted_slot = '0;
		rsp_nxt.free_count = free_now;
		if (cmd.fill_done) begin
			rsp_nxt.status = ST_OK;
			rsp_nxt.free_count = fill_n_q;
		end else begin
			unique case (op_q)
				OP_ALLOC: begin
					if (!init_q) begin
						rsp_nxt.status = ST_INVALID;
					end else if (alloc_full) begin
						rsp_nxt.status = ST_FULL;
					end else begin
						rsp_nxt.status = ST_OK;
						rsp_nxt.granted_slot = head_q[IDX_W-1:0];
						rsp_nxt.free_count = pool_q - used_q - CODE_W'(1);
					end
				end
				OP_FREE: begin
					if (slot_alloc) begin
						rsp_nxt.status = ST_OK;
						rsp_nxt.free_count = pool_q - used_q + CODE_W'(1);
					end
				end
				OP_CHECK: begin
					if (slot_alloc) begin
						rsp_nxt.status = ST_OK;
					end
				end
				default: begin
					rsp_nxt.status = ST_INVALID;
				end
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q <= CODE_W'(MAX_SLOTS);
			head_q <= CODE_END;
			used_q <= '0;
			pool_q <= '0;
			init_q <= 1'b0;
			done_q <= 1'b0;
		end else begin
			if (cfg_we) begin
				cfg_q <= cfg_wdata;
			end
			done_q <= cmd.exec || cmd.fill_done;
			if (cmd.fill_done) begin
				pool_q <= fill_n_q;
				head_q <= '0;
				used_q <= '0;
				init_q <= 1'b1;
			end else if (cmd.exec && alloc_ok) begin
				head_q <= rdata_q;
				used_q <= used_q + CODE_W'(1);
			end else if (cmd.exec && free_ok) begin
				head_q <= {1'b0, idx_q};
				used_q <= used_q - CODE_W'(1);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.accept) begin
			op_q <= req.op;
			idx_q <= req.slot_index;
			fill_n_q <= cfg_q;
			fill_cnt_q <= '0;
		end else if (cmd.fill) begin
			fill_cnt_q <= fill_next[IDX_W-1:0];
		end
		if (cmd.exec || cmd.fill_done) begin
			rsp_q <= rsp_nxt;
		end
	end

	assign done = done_q;
	assign rsp = rsp_q;

	assert property (@(posedge clk) disable iff (!arst_n)
		init_q |-> (used_q <= pool_q))
		else $error("used count beyond pool size");

	assert property (@(posedge clk) disable iff (!arst_n)
		!init_q |-> (used_q == '0 && head_q == CODE_END))
		else $error("pool state changed before reinit");

	assert property (@(posedge clk) disable iff (!arst_n)
		init_q |-> (head_q < pool_q || head_q == CODE_END))
		else $error("free-list head out of range");

	// an empty free list means every slot is handed out
	assert property (@(posedge clk) disable iff (!arst_n)
		(init_q && head_q == CODE_END) |-> (used_q == pool_q))
		else $error("free list lost slots");

endmodule

FILE: test/tb_fixed_slot_pool_allocator.sv
`timescale 1ns / 100ps

module tb_fixed_slot_pool_allocator;
	import fspa_pkg::*;

	localparam int RANDOM_ITEMS = 1650;
	localparam int CYCLE_LIMIT = 1500000;
	localparam int N_ROWS = 32;

	typedef struct packed {
		logic       is_cfg;
		logic [8:0] cfg_val;
		req_t       rq;
		logic       typed;
		rsp_t       want;
	} dir_row_t;

	localparam req_t NO_REQ = '{OP_REINIT, 8'd0};
	localparam rsp_t NO_RSP = '{ST_OK, 8'd0, 9'd0};

	// Directed walk: unready pool, bad sizes, full pool, empty pool, range checks
	localparam dir_row_t DIR_ROWS [0:N_ROWS-1] = '{
		'{1'b0, 9'd0, '{OP_ALLOC, 8'd0}, 1'b1, '{ST_INVALID, 8'd0, 9'd0}},
		'{1'b0, 9'd0, '{OP_FREE, 8'd255}, 1'b1, '{ST_INVALID, 8'd0, 9'd0}},
		'{1'b0, 9'd0, '{OP_CHECK, 8'd0}, 1'b1, '{ST_INVALID, 8'd0, 9'd0}},
		'{1'b1, 9'd0, NO_REQ, 1'b0, NO_RSP},
		'{1'b0, 9'd0, '{OP_REINIT, 8'd0}, 1'b1, '{ST_INVALID, 8'd0, 9'd0}},
		'{1'b1, 9'd256, NO_REQ, 1'b0, NO_RSP},
		'{1'b0, 9'd0, '{OP_REINIT, 8'd255}, 1'b1, '{ST_OK, 8'd0, 9'd256}},
		'{1'b0, 9'd0, '{OP_ALLOC, 8'd255}, 1'b1, '{ST_OK, 8'd0, 9'd255}},
		'{1'b0, 9'd0, '{OP_ALLOC, 8'd0}, 1'b1, '{ST_OK, 8'd1, 9'd254}},
		'{1'b0, 9'd0, '{OP_CHECK, 8'd1}, 1'b1, '{ST_OK, 8'd0, 9'd254}},
		'{1'b0, 9'd0, '{OP_CHECK, 8'd255}, 1'b1, '{ST_INVALID, 8'd0, 9'd254}},
		'{1'b0, 9'd0, '{OP_FREE, 8'd0}, 1'b1, '{ST_OK, 8'd0, 9'd255}},
		'{1'b0, 9'd0, '{OP_FREE, 8'd0}, 1'b1, '{ST_INVALID, 8'd0, 9'd255}},
		'{1'b0, 9'd0, '{OP_ALLOC, 8'd0}, 1'b0, NO_RSP},
		'{1'b0, 9'd0, '{OP_ALLOC, 8'd0}, 1'b0, NO_RSP},
		'{1'b1, 9'd2, NO_REQ, 1'b0, NO_RSP},
		'{1'b0, 9'd0, '{OP_REINIT, 8'd0}, 1'b1, '{ST_OK, 8'd0, 9'd2}},
		'{1'b0, 9'd0, '{OP_ALLOC, 8'd0}, 1'b1, '{ST_OK, 8'd0, 9'd1}},
		'{1'b0, 9'd0, '{OP_ALLOC, 8'd0}, 1'b1, '{ST_OK, 8'd1, 9'd0}},
		'{1'b0, 9'd0, '{OP_ALLOC, 8'd0}, 1'b1, '{ST_FULL, 8'd0, 9'd0}},
		'{1'b0, 9'd0, '{OP_FREE, 8'd2}, 1'b1, '{ST_INVALID, 8'd0, 9'd0}},
		'{1'b1, 9'd257, NO_REQ, 1'b0, NO_RSP},
		'{1'b0, 9'd0, '{OP_REINIT, 8'd0}, 1'b1, '{ST_INVALID, 8'd0, 9'd0}},
		'{1'b0, 9'd0, '{OP_CHECK, 8'd1}, 1'b1, '{ST_OK, 8'd0, 9'd0}},
		'{1'b0, 9'd0, '{OP_FREE, 8'd1}, 1'b1, '{ST_OK, 8'd0, 9'd1}},
		'{1'b0, 9'd0, '{OP_FREE, 8'd0}, 1'b1, '{ST_OK, 8'd0, 9'd2}},
		'{1'b0, 9'd0, '{OP_CHECK, 8'd0}, 1'b1, '{ST_INVALID, 8'd0, 9'd2}},
		'{1'b1, 9'd511, NO_REQ, 1'b0, NO_RSP},
		'{1'b0, 9'd0, '{OP_REINIT, 8'd0}, 1'b1, '{ST_INVALID, 8'd0, 9'd2}},
		'{1'b1, 9'd1, NO_REQ, 1'b0, NO_RSP},
		'{1'b0, 9'd0, '{OP_REINIT, 8'd0}, 1'b1, '{ST_INVALID, 8'd0, 9'd2}},
		'{1'b0, 9'd0, '{OP_ALLOC, 8'd0}, 1'b0, NO_RSP}
	};

	logic       clk = 1'b0;
	logic       arst_n = 1'b0;
	logic       start = 1'b0;
	req_t       req = NO_REQ;
	logic       busy;
	logic       done;
	rsp_t       rsp;
	logic       cfg_we = 1'b0;
	logic [8:0] cfg_wdata = 9'd0;

	fixed_slot_pool_allocator u_dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.start     (start),
		.req       (req),
		.busy      (busy),
		.done      (done),
		.rsp       (rsp),
		.cfg_we    (cfg_we),
		.cfg_wdata (cfg_wdata)
	);

	always #4 clk = ~clk;

	// Shadow of the pool
	logic [8:0] link_tbl [MAX_SLOTS];
	logic [8:0] free_head = CODE_END;
	logic [8:0] used_slots = '0;
	logic [8:0] pool_slots = '0;
	logic [8:0] size_reg = 9'd256;
	logic       pool_ready = 1'b0;

	rsp_t want_rsp_q [$];
	int   err_count = 0;
	int   cycle_count = 0;
	int   burst_left = 0;

	task automatic report_mismatch(input string msg);
		$display("%0t ERROR %s", $time, msg);
		err_count++;
	endtask

	function automatic bit slot_held(input logic [7:0] idx);
		return pool_ready && used_slots != 0 && {1'b0, idx} < pool_slots &&
			link_tbl[idx] == CODE_ALLOCATED;
	endfunction

	function automatic rsp_t pool_step(input req_t r);
		rsp_t       o;
		int         n;
		logic [8:0] at;
		o.status = ST_INVALID;
		o.granted_slot = '0;
		case (r.op)
			OP_REINIT: begin
				n = int'(size_reg);
				if (n >= MIN_SLOTS && n <= MAX_SLOTS) begin
					for (int i = 0; i < n; i++)
						link_tbl[i] = (i + 1 < n) ? 9'(i + 1) : CODE_END;
					pool_slots = size_reg;
					free_head = '0;
					used_slots = '0;
					pool_ready = 1'b1;
					o.status = ST_OK;
				end
			end
			OP_ALLOC: begin
				if (pool_ready) begin
					if (used_slots >= pool_slots || free_head >= pool_slots) begin
						o.status = ST_FULL;
					end else begin
						at = free_head;
						o.granted_slot = at[7:0];
						free_head = link_tbl[at[7:0]];
						link_tbl[at[7:0]] = CODE_ALLOCATED;
						used_slots++;
						o.status = ST_OK;
					end
				end
			end
			OP_FREE: begin
				if (slot_held(r.slot_index)) begin
					link_tbl[r.slot_index] = free_head;
					free_head = {1'b0, r.slot_index};
					used_slots--;
					o.status = ST_OK;
				end
			end
			default: begin
				if (slot_held(r.slot_index))
					o.status = ST_OK;
			end
		endcase
		o.free_count = pool_ready ? pool_slots - used_slots : '0;
		return o;
	endfunction

	// Pick one allocated slot at random, or -1 when none is out
	function automatic int pick_held_slot();
		int cnt;
		int k;
		cnt = 0;
		for (int i = 0; i < MAX_SLOTS; i++)
			if (slot_held(8'(i)))
				cnt++;
		if (cnt == 0)
			return -1;
		k = $urandom_range(0, cnt - 1);
		for (int i = 0; i < MAX_SLOTS; i++) begin
			if (slot_held(8'(i))) begin
				if (k == 0)
					return i;
				k--;
			end
		end
		return -1;
	endfunction

	// Hold start until the request is taken, then record its result
	task automatic issue(input req_t r, input bit typed, input rsp_t want);
		rsp_t got;
		start <= 1'b1;
		req <= r;
		do
			@(posedge clk);
		while (busy);
		got = pool_step(r);
		want_rsp_q.push_back(typed ? want : got);
	endtask

	// Every caller that drops start then waits on the clock; this one waits until no result is outstanding and busy is low
	task automatic drain();
		start <= 1'b0;
		do
			@(posedge clk);
		while (want_rsp_q.size() != 0 || busy);
	endtask

	task automatic write_size(input logic [8:0] v);
		cfg_we <= 1'b1;
		cfg_wdata <= v;
		@(posedge clk);
		cfg_we <= 1'b0;
		size_reg = v;
	endtask

	task automatic pace();
		if ($urandom_range(0, 99) < 2) begin
			drain();
		end else if (burst_left > 0) begin
			burst_left--;
		end else begin
			start <= 1'b0;
			repeat ($urandom_range(1, 7)) @(posedge clk);
			burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(30, 80) :
				$urandom_range(0, 12);
		end
	endtask

	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("TEST FAILED");
			$finish;
		end
	end

	always @(posedge clk) begin
		rsp_t exp_rsp;
		if (arst_n && done) begin
			if (want_rsp_q.size() == 0) begin
				report_mismatch($sformatf("unexpected result status=%0d slot=%0d free=%0d",
					rsp.status, rsp.granted_slot, rsp.free_count));
			end else begin
				exp_rsp = want_rsp_q.pop_front();
				if (rsp.status !== exp_rsp.status)
					report_mismatch($sformatf("status got %0d want %0d",
						rsp.status, exp_rsp.status));
				if (rsp.granted_slot !== exp_rsp.granted_slot)
					report_mismatch($sformatf("granted_slot got %0d want %0d",
						rsp.granted_slot, exp_rsp.granted_slot));
				if (rsp.free_count !== exp_rsp.free_count)
					report_mismatch($sformatf("free_count got %0d want %0d",
						rsp.free_count, exp_rsp.free_count));
			end
		end
	end

	initial begin
		int         sent;
		int         phase_len;
		int         alloc_pct;
		int         roll;
		int         held;
		logic [8:0] new_size;
		req_t       rq;
		sent = 0;
		for (int i = 0; i < MAX_SLOTS; i++)
			link_tbl[i] = '0;
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		for (int i = 0; i < N_ROWS; i++) begin
			if (DIR_ROWS[i].is_cfg) begin
				drain();
				write_size(DIR_ROWS[i].cfg_val);
			end else begin
				issue(DIR_ROWS[i].rq, DIR_ROWS[i].typed, DIR_ROWS[i].want);
				pace();
			end
		end

		while (sent < RANDOM_ITEMS) begin
			drain();
			roll = $urandom_range(0, 99);
			if (roll < 55)
				new_size = 9'($urandom_range(2, 12));
			else if (roll < 70)
				new_size = 9'($urandom_range(13, 64));
			else if (roll < 80)
				new_size = 9'd256;
			else if (roll < 88)
				new_size = 9'($urandom_range(65, 255));
			else if (roll < 91)
				new_size = 9'($urandom_range(0, 1));
			else
				new_size = 9'($urandom_range(257, 511));
			write_size(new_size);
			issue('{OP_REINIT, 8'($urandom_range(0, 255))}, 1'b0, NO_RSP);
			pace();
			sent++;
			phase_len = $urandom_range(10, 90);
			alloc_pct = $urandom_range(25, 60);
			for (int k = 0; k < phase_len && sent < RANDOM_ITEMS; k++) begin
				roll = $urandom_range(0, 99);
				rq.slot_index = 8'($urandom_range(0, 255));
				if (roll < 3)
					rq.op = OP_REINIT;
				else if (roll < 3 + alloc_pct)
					rq.op = OP_ALLOC;
				else if (roll < 85)
					rq.op = OP_FREE;
				else
					rq.op = OP_CHECK;
				if (rq.op == OP_FREE || rq.op == OP_CHECK) begin
					roll = $urandom_range(0, 99);
					held = (roll < 65) ? pick_held_slot() : -1;
					if (held >= 0)
						rq.slot_index = 8'(held);
					else if (roll < 85 && pool_slots != 0)
						rq.slot_index = 8'($urandom_range(0, int'(pool_slots) - 1));
				end
				issue(rq, 1'b0, NO_RSP);
				pace();
				sent++;
			end
		end

		drain();
		repeat (10) @(posedge clk);
		if (err_count == 0 && want_rsp_q.size() == 0) begin
			$display("TEST PASSED");
		end else begin
			$display("TEST FAILED");
		end
		$finish;
	end

endmodule

FILE: sim.f
hdl/fspa_pkg.sv
hdl/fspa_ctrl.sv
hdl/fspa_datapath.sv
hdl/fixed_slot_pool_allocator.sv
test/tb_fixed_slot_pool_allocator.sv
